>>> rtl/assert_macros.svh
// Assertion macros for the timer table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define PTT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("timer table assertion failed");
// Check that a condition never holds outside reset.
`define PTT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("timer table forbidden condition seen");
`else
`define PTT_ASSERT(lbl, clk, rst_n, prop)
`define PTT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> rtl/ptt_pkg.sv
// Types, codes and sizes shared by the timer table modules.
package ptt_pkg;
  localparam int unsigned SLOTS     = 16;
  localparam int unsigned MAX_FIRE  = 16;
  localparam int unsigned AW        = $clog2(SLOTS);
  localparam int unsigned CW        = $clog2(SLOTS + 1);
  localparam int unsigned FW        = $clog2(MAX_FIRE + 1);

  typedef enum logic [2:0] {
    K_TICK    = 3'd0,
    K_ADD     = 3'd1,
    K_DELETE  = 3'd2,
    K_DELOWN  = 3'd3,
    K_EXISTS  = 3'd4,
    K_MINWAIT = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    ST_FIRED     = 4'd0,
    ST_NONE_DUE  = 4'd1,
    ST_ADDED     = 4'd2,
    ST_FULL      = 4'd3,
    ST_DELETED   = 4'd4,
    ST_NOT_FOUND = 4'd5,
    ST_FOUND     = 4'd6,
    ST_OWN_CLR   = 4'd7,
    ST_WAIT      = 4'd8,
    ST_EMPTY     = 4'd9
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_TRD, S_TEV, S_TMV, S_FEV, S_REV, S_CHK, S_IEV, S_OEV, S_WAIT
  } state_e;

  // One timer as stored in the ordered list memory.
  typedef struct packed {
    logic [15:0] owner;
    logic [31:0] tid;
    logic [31:0] itv;
    logic [63:0] dl;
    logic [31:0] par;
  } entry_t;

  localparam int unsigned EW = $bits(entry_t);
endpackage

>>> rtl/periodic_timer_table.sv
// Periodic timer table kept in deadline order in one list memory.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+----------------------
//  command  | kind, owner, timer_id, interval, param  | start_i & !busy_o
//  result   | status, fired fields, wait_ms, last     | valid_o, one cycle
//
// Exists, delete, delete-by-owner and add walk the ordered list one entry per
// cycle through the single memory read port; a tick walks it again for each
// fired timer, and min-wait reads only the head entry.
// Reset clears the time counter and the entry count; the list memory needs no
// clearing since only live entries are read. Results cannot be stalled.
module periodic_timer_table
  import ptt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  kind_i,
  input  logic [15:0] owner_i,
  input  logic [31:0] timer_id_i,
  input  logic [31:0] interval_ms_i,
  input  logic [31:0] user_param_i,
  output logic        valid_o,
  output logic [3:0]  status_o,
  output logic [15:0] fired_owner_o,
  output logic [31:0] fired_timer_id_o,
  output logic [31:0] fired_param_o,
  output logic [31:0] wait_ms_o,
  output logic        last_o
);
  `include "assert_macros.svh"

  state_e        state_q, state_d;
  logic [63:0]   now_q, now_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] k_q, k_d, pos_q, pos_d, w_q, w_d;
  logic [FW-1:0] fired_q, fired_d;
  logic          ins_q, ins_d;
  logic [2:0]    kind_q, kind_d;
  logic [15:0]   own_q, own_d;
  logic [31:0]   tid_q, tid_d;
  entry_t        cur_q, cur_d, carry_q, carry_d;

  // pending fired result, held until the next one shows whether it is last
  logic          pv_q, pv_d;
  logic [15:0]   p_own_q, p_own_d;
  logic [31:0]   p_tid_q, p_tid_d, p_par_q, p_par_d;

  logic          ov_q, ov_d, ol_q, ol_d;
  logic [3:0]    ost_q, ost_d;
  logic [15:0]   oown_q, oown_d;
  logic [31:0]   otid_q, otid_d, opar_q, opar_d, owait_q, owait_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;
  logic [EW-1:0] rdata_raw;
  logic [CW-1:0] k_inc;
  logic          k_live, match;
  logic [63:0]   nd, diff;
  logic [31:0]   itv_fix;

  ptt_ram #(.Width(EW), .Depth(SLOTS)) u_list (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  assign rdata   = entry_t'(rdata_raw);
  assign k_inc   = k_q + CW'(1);
  assign k_live  = (k_q < cnt_q);
  assign match   = (rdata.owner == own_q) && (rdata.tid == tid_q);
  assign nd      = now_q + {32'd0, rdata.itv};
  assign diff    = rdata.dl - now_q;
  assign itv_fix = (interval_ms_i == 32'd0) ? 32'd1 : interval_ms_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (kind_i)
            K_TICK:    state_d = S_TRD;
            K_ADD:     state_d = S_FEV;
            K_DELETE:  state_d = S_FEV;
            K_EXISTS:  state_d = S_FEV;
            K_DELOWN:  state_d = S_OEV;
            K_MINWAIT: state_d = (cnt_q == '0) ? S_IDLE : S_WAIT;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_TRD: state_d = S_TEV;
      S_TEV: begin
        if (pos_q >= cnt_q || fired_q == FW'(MAX_FIRE) || now_q < rdata.dl) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_TMV;
        end
      end
      S_TMV: begin
        if (!(k_live && rdata.dl < cur_q.dl)) state_d = S_TRD;
      end
      S_FEV: begin
        if (!k_live) begin
          state_d = (kind_q == K_ADD) ? S_CHK : S_IDLE;
        end else if (match) begin
          state_d = (kind_q == K_EXISTS) ? S_IDLE : S_REV;
        end
      end
      S_REV: begin
        if (!k_live) state_d = (kind_q == K_ADD) ? S_CHK : S_IDLE;
      end
      S_CHK: state_d = (cnt_q == CW'(SLOTS)) ? S_IDLE : S_IEV;
      S_IEV: if (!k_live) state_d = S_IDLE;
      S_OEV: if (!k_live) state_d = S_IDLE;
      S_WAIT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath, memory access and result words
  always_comb begin
    now_d = now_q;  cnt_d = cnt_q;  k_d = k_q;  pos_d = pos_q;  w_d = w_q;
    fired_d = fired_q;  ins_d = ins_q;  kind_d = kind_q;  own_d = own_q;
    tid_d = tid_q;  cur_d = cur_q;  carry_d = carry_q;
    pv_d = pv_q;  p_own_d = p_own_q;  p_tid_d = p_tid_q;  p_par_d = p_par_q;
    ov_d = 1'b0;  ol_d = 1'b1;  ost_d = ST_NONE_DUE;
    oown_d = '0;  otid_d = '0;  opar_d = '0;  owait_d = '0;
    we = 1'b0;  waddr = k_q[AW-1:0];  wdata = rdata;
    raddr = k_inc[AW-1:0];
    case (state_q)
      S_IDLE: begin
        raddr = '0;
        k_d   = '0;
        if (start_i) begin
          kind_d = kind_i;  own_d = owner_i;  tid_d = timer_id_i;
          pos_d = '0;  w_d = '0;  fired_d = '0;  pv_d = 1'b0;  ins_d = 1'b0;
          cur_d = '{owner: owner_i, tid: timer_id_i, itv: itv_fix,
                    dl: now_q + {32'd0, itv_fix}, par: user_param_i};
          case (kind_i)
            K_TICK: now_d = now_q + 64'd1;
            K_MINWAIT: begin
              if (cnt_q == '0) begin
                ov_d = 1'b1;  ost_d = ST_EMPTY;
              end
            end
            K_ADD, K_DELETE, K_EXISTS, K_DELOWN: ;
            default: ov_d = 1'b1;
          endcase
        end
      end
      S_TRD: raddr = pos_q[AW-1:0];
      S_TEV: begin
        if (pos_q >= cnt_q || fired_q == FW'(MAX_FIRE) || now_q < rdata.dl) begin
          // close the tick: last fired timer or none due
          ov_d = 1'b1;
          if (pv_q) begin
            ost_d = ST_FIRED;  oown_d = p_own_q;  otid_d = p_tid_q;  opar_d = p_par_q;
          end
        end else begin
          if (pv_q) begin
            ov_d = 1'b1;  ol_d = 1'b0;  ost_d = ST_FIRED;
            oown_d = p_own_q;  otid_d = p_tid_q;  opar_d = p_par_q;
          end
          pv_d = 1'b1;  p_own_d = rdata.owner;  p_tid_d = rdata.tid;  p_par_d = rdata.par;
          fired_d = fired_q + FW'(1);
          cur_d = rdata;
          cur_d.dl = nd;
          k_d   = pos_q + CW'(1);
          raddr = k_d[AW-1:0];
        end
      end
      S_TMV: begin
        // slide earlier deadlines down, then drop the rearmed timer in
        we    = 1'b1;
        waddr = AW'(k_q - CW'(1));
        if (k_live && rdata.dl < cur_q.dl) begin
          wdata = rdata;
          k_d   = k_inc;
        end else begin
          wdata = cur_q;
          if (k_q == pos_q + CW'(1)) pos_d = pos_q + CW'(1);
        end
      end
      S_FEV: begin
        if (!k_live) begin
          if (kind_q != K_ADD) begin
            ov_d = 1'b1;  ost_d = ST_NOT_FOUND;
          end
        end else if (match) begin
          if (kind_q == K_EXISTS) begin
            ov_d = 1'b1;  ost_d = ST_FOUND;
          end
          k_d = k_inc;
        end else begin
          k_d = k_inc;
        end
      end
      S_REV: begin
        if (k_live) begin
          we = 1'b1;  waddr = AW'(k_q - CW'(1));  wdata = rdata;
          k_d = k_inc;
        end else begin
          cnt_d = cnt_q - CW'(1);
          if (kind_q != K_ADD) begin
            ov_d = 1'b1;  ost_d = ST_DELETED;
          end
        end
      end
      S_CHK: begin
        raddr = '0;
        k_d   = '0;
        if (cnt_q == CW'(SLOTS)) begin
          ov_d = 1'b1;  ost_d = ST_FULL;
        end
      end
      S_IEV: begin
        // insert before the first strictly later deadline, carry the rest up
        we = 1'b1;
        if (k_live) begin
          if (!ins_q && cur_q.dl < rdata.dl) begin
            wdata = cur_q;  carry_d = rdata;  ins_d = 1'b1;
          end else if (ins_q) begin
            wdata = carry_q;  carry_d = rdata;
          end else begin
            we = 1'b0;
          end
          k_d = k_inc;
        end else begin
          wdata = ins_q ? carry_q : cur_q;
          cnt_d = cnt_q + CW'(1);
          ov_d  = 1'b1;  ost_d = ST_ADDED;
        end
      end
      S_OEV: begin
        // compact the list, dropping the owner's timers
        if (k_live) begin
          if (rdata.owner != own_q) begin
            we = 1'b1;  waddr = w_q[AW-1:0];  wdata = rdata;
            w_d = w_q + CW'(1);
          end
          k_d = k_inc;
        end else begin
          cnt_d = w_q;
          ov_d  = 1'b1;  ost_d = ST_OWN_CLR;
        end
      end
      S_WAIT: begin
        ov_d = 1'b1;  ost_d = ST_WAIT;
        if (rdata.dl > now_q) begin
          owait_d = (diff[63:32] != 32'd0) ? 32'hFFFF_FFFF : diff[31:0];
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      now_q   <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      now_q   <= now_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  // Working and result words
  always_ff @(posedge clk_i) begin
    k_q <= k_d;  pos_q <= pos_d;  w_q <= w_d;  fired_q <= fired_d;  ins_q <= ins_d;
    kind_q <= kind_d;  own_q <= own_d;  tid_q <= tid_d;
    cur_q <= cur_d;  carry_q <= carry_d;
    pv_q <= pv_d;  p_own_q <= p_own_d;  p_tid_q <= p_tid_d;  p_par_q <= p_par_d;
    ol_q <= ol_d;  ost_q <= ost_d;  oown_q <= oown_d;  otid_q <= otid_d;
    opar_q <= opar_d;  owait_q <= owait_d;
  end

  assign busy_o           = (state_q != S_IDLE);
  assign valid_o          = ov_q;
  assign status_o         = ost_q;
  assign fired_owner_o    = oown_q;
  assign fired_timer_id_o = otid_q;
  assign fired_param_o    = opar_q;
  assign wait_ms_o        = owait_q;
  assign last_o           = ol_q;

  `PTT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q > CW'(SLOTS))
  `PTT_ASSERT(a_end_gives_word, clk_i, rst_ni, $fell(busy_o) |-> valid_o)
  `PTT_ASSERT(a_accept_acts, clk_i, rst_ni, (start_i && !busy_o) |=> (busy_o || valid_o))
endmodule

>>> rtl/ptt_ram.sv
// Generic single-write, single-read memory with registered read data.
module ptt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // Write one word, read one word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> bench/timer_table_checker.sv
// Checker for the periodic timer table: predicts every result word and compares it.
module timer_table_checker
  import ptt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_o,
  input  logic [2:0]  kind_i,
  input  logic [15:0] owner_i,
  input  logic [31:0] timer_id_i,
  input  logic [31:0] interval_ms_i,
  input  logic [31:0] user_param_i,
  input  logic        valid_o,
  input  logic [3:0]  status_o,
  input  logic [15:0] fired_owner_o,
  input  logic [31:0] fired_timer_id_o,
  input  logic [31:0] fired_param_o,
  input  logic [31:0] wait_ms_o,
  input  logic        last_o,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] owner;
    logic [31:0] tid;
    logic [31:0] par;
    logic [31:0] wait_ms;
    logic        last;
  } result_t;

  result_t        expected_q[$];

  // Predicted table contents
  logic [63:0]    clock_ms;
  int unsigned    live;
  logic [AW-1:0]  order[SLOTS];
  logic [15:0]    t_owner[SLOTS];
  logic [31:0]    t_tid[SLOTS];
  logic [31:0]    t_itv[SLOTS];
  logic [63:0]    t_dl[SLOTS];
  logic [31:0]    t_par[SLOTS];

  function automatic void push_word(status_e st, logic [15:0] own, logic [31:0] tid,
                                    logic [31:0] par, logic [31:0] w);
    result_t r;
    r.status = st; r.owner = own; r.tid = tid; r.par = par; r.wait_ms = w; r.last = 1'b0;
    expected_q.push_back(r);
  endfunction

  function automatic void drop_at(int unsigned pos);
    for (int unsigned i = pos; i + 1 < live; i++) order[i] = order[i + 1];
    live--;
  endfunction

  function automatic int locate(logic [15:0] own, logic [31:0] tid);
    for (int unsigned i = 0; i < live; i++)
      if (t_owner[order[i]] == own && t_tid[order[i]] == tid) return i;
    return -1;
  endfunction

  // Advance time and fire due timers, rearming each in deadline order
  function automatic void fire_due();
    int unsigned pos, j, fired, s;
    logic [63:0] nd;
    pos = 0;
    fired = 0;
    clock_ms = clock_ms + 64'd1;
    while (pos < live && fired < MAX_FIRE) begin
      s = int'(order[pos]);
      if (clock_ms < t_dl[s]) break;
      nd = clock_ms + {32'd0, t_itv[s]};
      t_dl[s] = nd;
      j = pos + 1;
      while (j < live && t_dl[order[j]] < nd) j++;
      for (int unsigned i = pos; i + 1 < j; i++) order[i] = order[i + 1];
      order[j - 1] = AW'(s);
      push_word(ST_FIRED, t_owner[s], t_tid[s], t_par[s], 32'd0);
      fired++;
      if (j == pos + 1) pos++;
    end
    if (fired == 0) push_word(ST_NONE_DUE, '0, '0, '0, '0);
  endfunction

  // Replace or insert a timer after the last entry with deadline not above it
  function automatic status_e insert_timer(logic [15:0] own, logic [31:0] tid,
                                           logic [31:0] itv, logic [31:0] par);
    logic [63:0] nd;
    int unsigned ins, s;
    bit used;
    int p;
    if (itv == 0) itv = 32'd1;
    nd = clock_ms + {32'd0, itv};
    p = locate(own, tid);
    while (p >= 0) begin
      drop_at(p);
      p = locate(own, tid);
    end
    if (live >= SLOTS) return ST_FULL;
    ins = live;
    for (int unsigned i = 0; i < live; i++)
      if (nd < t_dl[order[i]]) begin
        ins = i;
        break;
      end
    s = 0;
    for (int unsigned c = 0; c < SLOTS; c++) begin
      used = 0;
      for (int unsigned i = 0; i < live; i++) if (order[i] == c) used = 1;
      if (!used) begin
        s = c;
        break;
      end
    end
    for (int unsigned i = live; i > ins; i--) order[i] = order[i - 1];
    order[ins] = AW'(s);
    live++;
    t_owner[s] = own; t_tid[s] = tid; t_itv[s] = itv; t_dl[s] = nd; t_par[s] = par;
    return ST_ADDED;
  endfunction

  function automatic void predict_command(logic [2:0] kind, logic [15:0] own,
                                          logic [31:0] tid, logic [31:0] itv,
                                          logic [31:0] par);
    int p;
    int unsigned i;
    logic [63:0] d, w;
    case (kind)
      K_TICK: fire_due();
      K_ADD: push_word(insert_timer(own, tid, itv, par), '0, '0, '0, '0);
      K_DELETE: begin
        p = locate(own, tid);
        if (p >= 0) drop_at(p);
        push_word(p >= 0 ? ST_DELETED : ST_NOT_FOUND, '0, '0, '0, '0);
      end
      K_DELOWN: begin
        i = 0;
        while (i < live) begin
          if (t_owner[order[i]] == own) drop_at(i);
          else i++;
        end
        push_word(ST_OWN_CLR, '0, '0, '0, '0);
      end
      K_EXISTS: push_word(locate(own, tid) >= 0 ? ST_FOUND : ST_NOT_FOUND, '0, '0, '0, '0);
      K_MINWAIT: begin
        if (live == 0) begin
          push_word(ST_EMPTY, '0, '0, '0, '0);
        end else begin
          d = t_dl[order[0]];
          w = (d > clock_ms) ? d - clock_ms : 64'd0;
          if (w > 64'hFFFF_FFFF) w = 64'hFFFF_FFFF;
          push_word(ST_WAIT, '0, '0, '0, w[31:0]);
        end
      end
      default: push_word(ST_NONE_DUE, '0, '0, '0, '0);
    endcase
    expected_q[$].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    errors_o++;
  endtask

  initial begin
    errors_o = 0;
    pending_o = 0;
  end

  // Predict on accepted commands, compare each result word with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    result_t e;
    if (!rst_ni) begin
      clock_ms = '0;
      live = 0;
      expected_q.delete();
    end else begin
      if (valid_o) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word, status", status_o, 0);
        end else begin
          e = expected_q.pop_front();
          if (status_o !== e.status) report_mismatch("status", status_o, e.status);
          if (fired_owner_o !== e.owner) report_mismatch("fired_owner", fired_owner_o, e.owner);
          if (fired_timer_id_o !== e.tid) report_mismatch("fired_timer_id", fired_timer_id_o, e.tid);
          if (fired_param_o !== e.par) report_mismatch("fired_param", fired_param_o, e.par);
          if (wait_ms_o !== e.wait_ms) report_mismatch("wait_ms", wait_ms_o, e.wait_ms);
          if (last_o !== e.last) report_mismatch("last", last_o, e.last);
        end
      end
      if (start_i && !busy_o)
        predict_command(kind_i, owner_i, timer_id_i, interval_ms_i, user_param_i);
      pending_o = expected_q.size();
    end
  end
endmodule

>>> bench/tb.sv
// Top of the timer table testbench: clock, reset, command stimulus and verdict.
module tb
  import ptt_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [2:0]  kind_i = '0;
  logic [15:0] owner_i = '0;
  logic [31:0] timer_id_i = '0;
  logic [31:0] interval_ms_i = '0;
  logic [31:0] user_param_i = '0;
  logic        valid_o;
  logic [3:0]  status_o;
  logic [15:0] fired_owner_o;
  logic [31:0] fired_timer_id_o;
  logic [31:0] fired_param_o;
  logic [31:0] wait_ms_o;
  logic        last_o;
  int          errors;
  int          pending;
  int          idle_cycles = 0;
  int          idle_pct = 0;
  int          idle_pct_list[4] = '{0, 81, 8, 0};

  periodic_timer_table i_dut (.*);

  timer_table_checker i_checker (.*, .errors_o(errors), .pending_o(pending));

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Count cycles in which no word moves on either side
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Drive one command word and hold it until it is taken
  task automatic send(logic [2:0] kind, logic [15:0] own, logic [31:0] tid,
                      logic [31:0] itv, logic [31:0] par);
    if ($urandom_range(99) < idle_pct) begin
      start_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    start_i = 1'b1;
    kind_i = kind; owner_i = own; timer_id_i = tid; interval_ms_i = itv; user_param_i = par;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  task automatic send_random();
    int unsigned k;
    logic [2:0]  kind;
    logic [15:0] own;
    logic [31:0] tid, itv;
    k = $urandom_range(99);
    if (k < 35) kind = K_TICK;
    else if (k < 65) kind = K_ADD;
    else if (k < 75) kind = K_DELETE;
    else if (k < 80) kind = K_DELOWN;
    else if (k < 88) kind = K_EXISTS;
    else if (k < 97) kind = K_MINWAIT;
    else kind = 3'($urandom_range(6, 7));
    own = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(3));
    tid = ($urandom_range(19) == 0) ? $urandom : 32'($urandom_range(7));
    k = $urandom_range(99);
    if (k < 75) itv = $urandom_range(1, 12);
    else if (k < 85) itv = 0;
    else itv = $urandom;
    send(kind, own, tid, itv, $urandom);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty table, unused kinds, field extremes
    send(K_TICK, '0, 0, 0, 0);
    send(K_MINWAIT, '0, 0, 0, 0);
    send(3'd6, 16'hFFFF, '1, '1, '1);
    send(3'd7, '0, 0, 0, 0);
    send(K_EXISTS, 16'hFFFF, '1, 0, 0);
    send(K_DELETE, '0, 0, 0, 0);
    send(K_ADD, 16'hFFFF, '1, '1, '1);
    send(K_ADD, '0, 0, 0, 32'h5A5A_A5A5);
    send(K_MINWAIT, '0, 0, 0, 0);
    send(K_ADD, '0, 0, 3, 32'h1234);
    send(K_EXISTS, '0, 0, 0, 0);
    // Fill the table, then overflow it
    for (int i = 0; i < 15; i++) send(K_ADD, 16'd7, i, 1 + (i % 2), i);
    send(K_ADD, 16'd8, 99, 1, 0);
    // Many due at once
    send(K_TICK, '0, 0, 0, 0);
    send(K_TICK, '0, 0, 0, 0);
    send(K_MINWAIT, '0, 0, 0, 0);
    send(K_DELETE, 16'hFFFF, '1, 0, 0);
    send(K_DELOWN, 16'd7, 0, 0, 0);
    send(K_DELOWN, 16'd0, 0, 0, 0);
    send(K_MINWAIT, '0, 0, 0, 0);

    // Random phases with different sender gaps
    foreach (idle_pct_list[p]) begin
      idle_pct = idle_pct_list[p];
      repeat (85) send_random();
    end
    start_i = 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl
rtl/ptt_pkg.sv
rtl/ptt_ram.sv
rtl/periodic_timer_table.sv
bench/timer_table_checker.sv
bench/tb.sv
